// ----- hw/rtl/arc_pkg.sv -----
// Shared types and constants for the address resolution cache.
`timescale 1ns / 1ps
package arc_pkg;

  // Command codes
  localparam logic [1:0] CMD_LOOKUP = 2'd0;
  localparam logic [1:0] CMD_RX_PKT = 2'd1;
  localparam logic [1:0] CMD_SENT   = 2'd2;

  // Result kinds
  localparam logic [2:0] KIND_NONE    = 3'd0;
  localparam logic [2:0] KIND_UNICAST = 3'd1;
  localparam logic [2:0] KIND_BCAST   = 3'd2;
  localparam logic [2:0] KIND_REQUEST = 3'd3;
  localparam logic [2:0] KIND_QUEUED  = 3'd4;
  localparam logic [2:0] KIND_DROPPED = 3'd5;

  // Configuration register indexes
  localparam logic [1:0] CFG_MY_NET     = 2'd0;
  localparam logic [1:0] CFG_HW_TYPE    = 2'd1;
  localparam logic [1:0] CFG_PROTO_TYPE = 2'd2;

  localparam logic [15:0] HW_TYPE_RST    = 16'd1;
  localparam logic [15:0] PROTO_TYPE_RST = 16'd2052;
  localparam logic [7:0]  PROTO_LEN_REQ  = 8'd2;
  localparam logic [47:0] BCAST_MAC      = 48'hFFFF_FFFF_FFFF;

  // One cache entry as stored in memory
  typedef struct packed {
    logic [15:0] net;
    logic [47:0] mac;
    logic [31:0] stamp;
  } entry_t;

  // Captured input beat
  typedef struct packed {
    logic [1:0]  cmd;
    logic [15:0] dest_net;
    logic        length_ok;
    logic [15:0] hw_type;
    logic [15:0] proto_type;
    logic [7:0]  proto_len;
    logic        is_request;
    logic [15:0] sender_net;
    logic [47:0] sender_mac;
    logic [15:0] target_net;
  } item_t;

  // Scan summary handed from the scanner to the control logic
  typedef struct packed {
    logic   hit;
    entry_t hit_word;
    logic   empty;
    logic [31:0] lru_stamp;
  } scan_sum_t;

endpackage

// ----- hw/rtl/address_resolution_cache_unit.sv -----
// Top level of the address resolution cache: control, config and result register.
`timescale 1ns / 1ps
//  channel | handshake          | payload
//  --------+--------------------+---------------------------------------------
//  in      | in_valid/in_stall  | cmd, dest_net, packet fields, sender, target
//  out     | out_valid/out_stall| kind, dest_mac, about_net, learned
//  cfg     | cfg_we             | cfg_idx, cfg_data (16 bits)
//
// Each beat is accepted from idle, then makes one read per entry
// from the single read port of the entry memory, waits out the read latency
// in a drain state, then decides and writes back. One beat is in flight at a time.
// Reset (rst_n low, synchronous) empties the cache at once through valid bits.
// A new beat is taken while a finished result waits; a stalled output holds
// the finishing beat in its decide cycle.
module address_resolution_cache_unit #(
  parameter int ENTRIES = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_we,
  input  logic [1:0]  cfg_idx,
  input  logic [15:0] cfg_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  in_cmd,
  input  logic [15:0] in_dest_net,
  input  logic        in_length_ok,
  input  logic [15:0] in_hw_type,
  input  logic [15:0] in_proto_type,
  input  logic [7:0]  in_proto_len,
  input  logic        in_is_request,
  input  logic [15:0] in_sender_net,
  input  logic [47:0] in_sender_mac,
  input  logic [15:0] in_target_net,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  out_kind,
  output logic [47:0] out_dest_mac,
  output logic [15:0] out_about_net,
  output logic        out_learned
);

  localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(ENTRIES - 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_SCAN  = 2'd1;
  localparam logic [1:0] ST_DRAIN = 2'd2;
  localparam logic [1:0] ST_FIN   = 2'd3;

  logic [1:0]         state_r, state_nxt;
  logic [IDX_W-1:0]   cnt_r, cnt_nxt;
  arc_pkg::item_t     item_r;
  logic [15:0]        my_net_r, hw_code_r, proto_code_r;
  logic [31:0]        use_clk_r, use_clk_nxt;
  logic               pend_r, pend_nxt;
  logic               out_valid_r, out_valid_nxt;
  logic [2:0]         out_kind_r;
  logic [47:0]        out_mac_r;
  logic [15:0]        out_about_r;
  logic               out_learned_r;

  logic               in_acc;
  logic               fin_go;
  logic               rd_en;
  logic               rsp_vld;
  logic [IDX_W-1:0]   rsp_idx;
  arc_pkg::entry_t    rsp_word;
  arc_pkg::scan_sum_t sum;
  logic [IDX_W-1:0]   hit_idx, emp_idx, lru_idx;
  logic [15:0]        key;

  logic               wr_en;
  logic [IDX_W-1:0]   wr_addr;
  arc_pkg::entry_t    wr_data;
  logic [2:0]         res_kind;
  logic [47:0]        res_mac;
  logic [15:0]        res_about;
  logic               res_learned;
  logic               pkt_ok;
  logic               for_us;

  assign in_stall = (state_r != ST_IDLE);
  assign in_acc   = in_valid && !in_stall;
  assign fin_go   = (state_r == ST_FIN) && (!out_valid_r || !out_stall);
  assign rd_en    = (state_r == ST_SCAN);
  assign key      = (item_r.cmd == arc_pkg::CMD_LOOKUP) ? item_r.dest_net
                                                         : item_r.sender_net;

  // Entry memory and scanner
  arc_mem #(.ENTRIES(ENTRIES), .IDX_W(IDX_W)) u_mem (
    .clk      (clk),
    .rst_n    (rst_n),
    .rd_en    (rd_en),
    .rd_addr  (cnt_r),
    .rsp_vld  (rsp_vld),
    .rsp_idx  (rsp_idx),
    .rsp_word (rsp_word),
    .wr_en    (wr_en),
    .wr_addr  (wr_addr),
    .wr_data  (wr_data)
  );

  arc_scan #(.IDX_W(IDX_W)) u_scan (
    .clk      (clk),
    .rst_n    (rst_n),
    .clr      (in_acc),
    .key      (key),
    .rsp_vld  (rsp_vld),
    .rsp_idx  (rsp_idx),
    .rsp_word (rsp_word),
    .sum      (sum),
    .hit_idx  (hit_idx),
    .emp_idx  (emp_idx),
    .lru_idx  (lru_idx)
  );

  // Configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      my_net_r     <= '0;
      hw_code_r    <= arc_pkg::HW_TYPE_RST;
      proto_code_r <= arc_pkg::PROTO_TYPE_RST;
    end else if (cfg_we) begin
      case (cfg_idx)
        arc_pkg::CFG_MY_NET:     my_net_r     <= cfg_data;
        arc_pkg::CFG_HW_TYPE:    hw_code_r    <= cfg_data;
        arc_pkg::CFG_PROTO_TYPE: proto_code_r <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer: accept, scan all entries, drain read latency, decide
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      ST_IDLE: begin
        cnt_nxt = '0;
        if (in_acc) begin
          state_nxt = ST_SCAN;
        end
      end
      ST_SCAN: begin
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == LAST_IDX) begin
          state_nxt = ST_DRAIN;
          cnt_nxt   = '0;
        end
      end
      ST_DRAIN: state_nxt = ST_FIN;
      ST_FIN: begin
        if (fin_go) begin
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // Decide the result and the single write-back
  always_comb begin
    pkt_ok = item_r.length_ok && (item_r.hw_type == hw_code_r) &&
             (item_r.proto_type == proto_code_r) &&
             (item_r.proto_len == arc_pkg::PROTO_LEN_REQ) &&
             (item_r.sender_net != 16'd0);
    for_us      = (item_r.target_net == my_net_r);
    wr_en       = 1'b0;
    wr_addr     = hit_idx;
    wr_data     = sum.hit_word;
    res_kind    = arc_pkg::KIND_NONE;
    res_mac     = '0;
    res_about   = '0;
    res_learned = 1'b0;
    use_clk_nxt = use_clk_r;
    pend_nxt    = pend_r;
    case (item_r.cmd)
      arc_pkg::CMD_LOOKUP: begin
        if (item_r.dest_net == 16'd0) begin
          res_kind = arc_pkg::KIND_BCAST;
          res_mac  = arc_pkg::BCAST_MAC;
        end else if (sum.hit) begin
          use_clk_nxt   = use_clk_r + 32'd1;
          wr_en         = fin_go;
          wr_data.stamp = use_clk_nxt;
          res_kind      = arc_pkg::KIND_UNICAST;
          res_mac       = sum.hit_word.mac;
        end else begin
          res_kind  = arc_pkg::KIND_REQUEST;
          res_about = item_r.dest_net;
        end
      end
      arc_pkg::CMD_RX_PKT: begin
        if (pkt_ok) begin
          if (sum.hit) begin
            wr_en       = fin_go;
            wr_data.mac = item_r.sender_mac;
            res_learned = 1'b1;
          end else if (for_us) begin
            // learn into the first empty slot, else the LRU slot (stamp kept)
            wr_en         = fin_go;
            wr_addr       = sum.empty ? emp_idx : lru_idx;
            wr_data.net   = item_r.sender_net;
            wr_data.mac   = item_r.sender_mac;
            wr_data.stamp = sum.empty ? 32'd0 : sum.lru_stamp;
            res_learned   = 1'b1;
          end
          if (for_us && item_r.is_request) begin
            if (pend_r) begin
              res_kind = arc_pkg::KIND_DROPPED;
            end else begin
              pend_nxt  = 1'b1;
              res_kind  = arc_pkg::KIND_QUEUED;
              res_mac   = item_r.sender_mac;
              res_about = item_r.sender_net;
            end
          end
        end
      end
      arc_pkg::CMD_SENT: pend_nxt = 1'b0;
      default: ;
    endcase
  end

  assign out_valid_nxt = fin_go ? 1'b1 : (out_valid_r && out_stall);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      use_clk_r   <= '0;
      pend_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
      if (fin_go) begin
        use_clk_r <= use_clk_nxt;
        pend_r    <= pend_nxt;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_r.cmd        <= in_cmd;
      item_r.dest_net   <= in_dest_net;
      item_r.length_ok  <= in_length_ok;
      item_r.hw_type    <= in_hw_type;
      item_r.proto_type <= in_proto_type;
      item_r.proto_len  <= in_proto_len;
      item_r.is_request <= in_is_request;
      item_r.sender_net <= in_sender_net;
      item_r.sender_mac <= in_sender_mac;
      item_r.target_net <= in_target_net;
    end
    if (fin_go) begin
      out_kind_r    <= res_kind;
      out_mac_r     <= res_mac;
      out_about_r   <= res_about;
      out_learned_r <= res_learned;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_kind      = out_kind_r;
  assign out_dest_mac  = out_mac_r;
  assign out_about_net = out_about_r;
  assign out_learned   = out_learned_r;

`ifndef SYNTH
  // memory is written back only in the decide cycle
  a_wr_in_fin: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en |-> (state_r == ST_FIN))
    else $error("entry write outside decide cycle");

  // read data only returns during the scan window
  a_rsp_window: assert property (@(posedge clk) disable iff (!rst_n)
    rsp_vld |-> ((state_r == ST_SCAN) || (state_r == ST_DRAIN)))
    else $error("read response outside scan");

  // an accepted beat starts a scan at entry zero
  a_acc_scan: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> ((state_r == ST_SCAN) && (cnt_r == '0)))
    else $error("accepted beat did not start a scan");

  // a finishing beat always lands in the result register
  a_fin_out: assert property (@(posedge clk) disable iff (!rst_n)
    fin_go |=> (out_valid_r && (state_r == ST_IDLE)))
    else $error("finished beat lost");
`endif

endmodule

// ----- hw/rtl/arc_mem.sv -----
// Entry memory: one write port, one registered read port, valid bit per entry.
`timescale 1ns / 1ps
module arc_mem #(
  parameter int ENTRIES = 16,
  parameter int IDX_W   = 4
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  rd_en,
  input  logic [IDX_W-1:0]      rd_addr,
  output logic                  rsp_vld,
  output logic [IDX_W-1:0]      rsp_idx,
  output arc_pkg::entry_t       rsp_word,
  input  logic                  wr_en,
  input  logic [IDX_W-1:0]      wr_addr,
  input  arc_pkg::entry_t       wr_data
);

  arc_pkg::entry_t    mem [ENTRIES];
  logic [ENTRIES-1:0] vld_r;
  arc_pkg::entry_t    rd_data_r;
  logic               rd_ok_r;
  logic               rsp_vld_r;
  logic [IDX_W-1:0]   rsp_idx_r;

  // Storage array and read data
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= mem[rd_addr];
      rsp_idx_r <= rd_addr;
    end
  end

  // Valid bits and read strobe; unwritten entries read as zero
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r     <= '0;
      rd_ok_r   <= 1'b0;
      rsp_vld_r <= 1'b0;
    end else begin
      if (wr_en) begin
        vld_r[wr_addr] <= 1'b1;
      end
      if (rd_en) begin
        rd_ok_r <= vld_r[rd_addr];
      end
      rsp_vld_r <= rd_en;
    end
  end

  assign rsp_vld  = rsp_vld_r;
  assign rsp_idx  = rsp_idx_r;
  assign rsp_word = rd_ok_r ? rd_data_r : '0;

endmodule

// ----- hw/rtl/arc_scan.sv -----
// Scan accumulator: first match, first empty slot and least recently used slot.
`timescale 1ns / 1ps
module arc_scan #(
  parameter int IDX_W = 4
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                clr,
  input  logic [15:0]         key,
  input  logic                rsp_vld,
  input  logic [IDX_W-1:0]    rsp_idx,
  input  arc_pkg::entry_t     rsp_word,
  output arc_pkg::scan_sum_t  sum,
  output logic [IDX_W-1:0]    hit_idx,
  output logic [IDX_W-1:0]    emp_idx,
  output logic [IDX_W-1:0]    lru_idx
);

  logic               hit_r;
  logic               emp_r;
  arc_pkg::entry_t    hit_word_r;
  logic [31:0]        lru_stamp_r;
  logic [IDX_W-1:0]   hit_idx_r;
  logic [IDX_W-1:0]   emp_idx_r;
  logic [IDX_W-1:0]   lru_idx_r;
  logic               is_match;
  logic               is_empty;
  logic               is_older;

  assign is_match = (key != 16'd0) && (rsp_word.net == key);
  assign is_empty = (rsp_word.net == 16'd0);
  // slot 0 always seeds the LRU candidate; strict compare keeps lowest index on ties
  assign is_older = (rsp_idx == '0) || (rsp_word.stamp < lru_stamp_r);

  // Flags
  always_ff @(posedge clk) begin
    if (!rst_n || clr) begin
      hit_r <= 1'b0;
      emp_r <= 1'b0;
    end else if (rsp_vld) begin
      if (is_match) begin
        hit_r <= 1'b1;
      end
      if (is_empty) begin
        emp_r <= 1'b1;
      end
    end
  end

  // Captured candidates
  always_ff @(posedge clk) begin
    if (rsp_vld) begin
      if (is_match && !hit_r) begin
        hit_word_r <= rsp_word;
        hit_idx_r  <= rsp_idx;
      end
      if (is_empty && !emp_r) begin
        emp_idx_r <= rsp_idx;
      end
      if (is_older) begin
        lru_stamp_r <= rsp_word.stamp;
        lru_idx_r   <= rsp_idx;
      end
    end
  end

  assign sum.hit       = hit_r;
  assign sum.hit_word  = hit_word_r;
  assign sum.empty     = emp_r;
  assign sum.lru_stamp = lru_stamp_r;
  assign hit_idx = hit_idx_r;
  assign emp_idx = emp_idx_r;
  assign lru_idx = lru_idx_r;

endmodule
